### hw/rtl/iee_pkg.sv
// shared types and constants for the infix expression evaluator
package iee_pkg;

    localparam int unsigned NumW = 32;
    localparam int unsigned ValW = 64;
    localparam int unsigned OpW  = 8;
    localparam int unsigned QDepth = 2;
    localparam int unsigned QIdxW  = 1;

    typedef enum logic [1:0] {
        REQ_NUM = 2'd0,
        REQ_OP  = 2'd1,
        REQ_END = 2'd2,
        REQ_BAD = 2'd3
    } t_req;

    localparam logic [OpW-1:0] OP_MUL = 8'h2A;
    localparam logic [OpW-1:0] OP_DIV = 8'h2F;
    localparam logic [OpW-1:0] OP_MOD = 8'h25;
    localparam logic [OpW-1:0] OP_ADD = 8'h2B;
    localparam logic [OpW-1:0] OP_SUB = 8'h2D;
    localparam logic [OpW-1:0] OP_AND = 8'h26;
    localparam logic [OpW-1:0] OP_OR  = 8'h7C;
    localparam logic [OpW-1:0] OP_XOR = 8'h5E;
    localparam logic [OpW-1:0] OP_LT  = 8'h3C;
    localparam logic [OpW-1:0] OP_GT  = 8'h3E;

    // classified request passed from front to back
    typedef struct packed {
        t_req             kind;
        logic [NumW-1:0]  num;
        logic [OpW-1:0]   op;
    } t_tok;

endpackage

### hw/rtl/iee_front.sv
// front end: accepts requests, casts the kind code to t_req, pushes into a short queue
module iee_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  logic [1:0]     i_req_type,
    input  logic [31:0]    i_number,
    input  logic [7:0]     i_operator_char,
    output logic           o_tok_valid,
    output iee_pkg::t_tok  o_tok,
    input  logic           i_tok_pop
);
    iee_pkg::t_tok r_q [iee_pkg::QDepth];
    logic [iee_pkg::QIdxW-1:0] r_wp, r_rp;
    logic [iee_pkg::QIdxW:0]   r_cnt;
    logic push;
    iee_pkg::t_tok tok_in;

    assign o_stall = (r_cnt == (iee_pkg::QIdxW+1)'(iee_pkg::QDepth)) ? 1'b1 : 1'b0;
    assign push = i_valid && !o_stall;
    assign o_tok_valid = (r_cnt != '0);
    assign o_tok = r_q[r_rp];

    always_comb begin
        tok_in.kind = iee_pkg::t_req'(i_req_type);
        tok_in.num  = i_number;
        tok_in.op   = i_operator_char;
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= tok_in;
        end
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= r_wp + 1'b1;
            if (i_tok_pop) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (iee_pkg::QIdxW+1)'(push) - (iee_pkg::QIdxW+1)'(i_tok_pop);
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (iee_pkg::QIdxW+1)'(iee_pkg::QDepth))
        else $error("queue overflow");
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_tok_pop |-> o_tok_valid)
        else $error("pop from empty queue");
    a_full_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == (iee_pkg::QIdxW+1)'(iee_pkg::QDepth)) |-> o_stall)
        else $error("full queue not stalling");
endmodule

### hw/rtl/iee_divider.sv
// 64-bit unsigned restoring divider, one quotient bit per cycle
module iee_divider (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [63:0]  i_dividend,
    input  logic [63:0]  i_divisor,
    output logic         o_done,
    output logic [63:0]  o_quot,
    output logic [63:0]  o_rem
);
    logic [63:0] r_q, r_r, r_d;
    logic [6:0]  r_cnt;
    logic        r_busy, r_done;
    logic [64:0] trial;

    assign trial = {r_r, r_q[63]} - {1'b0, r_d};
    assign o_done = r_done;
    assign o_quot = r_q;
    assign o_rem  = r_r;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 7'd64;
                r_q <= i_dividend;
                r_r <= '0;
                r_d <= i_divisor;
            end else if (r_busy) begin
                if (trial[64]) begin
                    r_r <= {r_r[62:0], r_q[63]};
                    r_q <= {r_q[62:0], 1'b0};
                end else begin
                    r_r <= trial[63:0];
                    r_q <= {r_q[62:0], 1'b1};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end
endmodule

### hw/rtl/iee_back.sv
// back end: evaluates tokens with two precedence levels and emits results
module iee_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_tok_valid,
    input  iee_pkg::t_tok  i_tok,
    output logic           o_tok_pop,
    output logic           o_valid,
    input  logic           i_stall,
    output logic [63:0]    o_value,
    output logic           o_status,
    output logic           o_div_by_zero,
    output logic           o_bad_operator
);
    typedef enum logic [2:0] {
        S_IDLE, S_MUL, S_DIVW, S_LOW, S_OUT
    } t_state;
    typedef enum logic [1:0] {
        PH_FIRST, PH_NUM, PH_OP
    } t_phase;

    t_state r_state;
    t_phase r_phase;
    logic [63:0] r_done_val, r_cur, r_a, r_b, r_prod;
    logic [7:0]  r_pend, r_wait, r_alu_op;
    logic        r_have, r_syn, r_dz, r_bad;
    logic        r_end, r_na, r_nb, r_is_mod, r_div_start;
    logic        r_valid;
    logic [63:0] r_value;
    logic        r_status, r_odz, r_obad;
    logic [1:0]  r_mstep;

    logic div_done;
    logic [63:0] quot, remd;
    logic [63:0] num_sx, low_res, ua, ub;
    logic low_bad, tight, div_go;
    logic [31:0] pa, pb;
    logic [63:0] pp;

    iee_divider u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_div_start),
        .i_dividend(r_na ? (64'd0 - r_a) : r_a),
        .i_divisor(r_nb ? (64'd0 - r_b) : r_b),
        .o_done(div_done), .o_quot(quot), .o_rem(remd)
    );

    assign num_sx = {{32{i_tok.num[31]}}, i_tok.num};
    assign tight = (r_wait == iee_pkg::OP_MUL) || (r_wait == iee_pkg::OP_DIV)
                 || (r_wait == iee_pkg::OP_MOD);
    assign ua = r_a;
    assign ub = r_b;
    assign o_tok_pop = (r_state == S_IDLE) && i_tok_valid && !(r_valid && i_stall);
    // divide or modulo with a nonzero divisor starts the divider
    assign div_go = o_tok_pop && (i_tok.kind == iee_pkg::REQ_NUM) && (r_phase == PH_NUM)
                  && tight && (r_wait != iee_pkg::OP_MUL) && (num_sx != '0);

    // 64x64 low product from three 32x32 partials, one per S_MUL step
    always_comb begin
        pa = '0;
        pb = '0;
        case (r_mstep)
            2'd0: begin pa = ua[31:0];  pb = ub[31:0];  end
            2'd1: begin pa = ua[31:0];  pb = ub[63:32]; end
            2'd2: begin pa = ua[63:32]; pb = ub[31:0];  end
            default: begin pa = '0; pb = '0; end
        endcase
        pp = pa * pb;
    end

    always_comb begin
        low_bad = 1'b0;
        case (r_alu_op)
            iee_pkg::OP_ADD: low_res = ua + ub;
            iee_pkg::OP_SUB: low_res = ua - ub;
            iee_pkg::OP_AND: low_res = ua & ub;
            iee_pkg::OP_OR:  low_res = ua | ub;
            iee_pkg::OP_XOR: low_res = ua ^ ub;
            iee_pkg::OP_LT:  low_res = {63'd0, $signed(ua) < $signed(ub)};
            iee_pkg::OP_GT:  low_res = {63'd0, $signed(ub) < $signed(ua)};
            default: begin low_res = '0; low_bad = 1'b1; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= PH_FIRST;
            r_done_val <= '0; r_cur <= '0; r_pend <= '0; r_wait <= '0;
            r_have <= 1'b0; r_syn <= 1'b0; r_dz <= 1'b0; r_bad <= 1'b0;
            r_valid <= 1'b0; r_div_start <= 1'b0; r_end <= 1'b0;
            r_mstep <= '0;
        end else begin
            r_div_start <= div_go;
            if (r_valid && !i_stall && (r_state != S_OUT)) r_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (o_tok_pop) begin
                        case (i_tok.kind)
                            iee_pkg::REQ_NUM: begin
                                if (r_phase == PH_FIRST) begin
                                    r_cur <= num_sx;
                                    r_phase <= PH_OP;
                                end else if (r_phase == PH_NUM) begin
                                    r_phase <= PH_OP;
                                    if (r_wait == iee_pkg::OP_MUL) begin
                                        r_a <= r_cur;
                                        r_b <= num_sx;
                                        r_mstep <= '0;
                                        r_prod <= '0;
                                        r_state <= S_MUL;
                                    end else if (tight) begin
                                        r_a <= r_cur;
                                        r_b <= num_sx;
                                        r_na <= r_cur[63];
                                        r_nb <= i_tok.num[31];
                                        r_is_mod <= (r_wait == iee_pkg::OP_MOD);
                                        if (num_sx == '0) begin
                                            r_dz <= 1'b1;
                                            r_cur <= '0;
                                        end else begin
                                            r_state <= S_DIVW;
                                        end
                                    end else begin
                                        r_pend <= r_wait;
                                        r_have <= 1'b1;
                                        r_cur <= num_sx;
                                        if (r_have) begin
                                            r_a <= r_done_val;
                                            r_b <= r_cur;
                                            r_alu_op <= r_pend;
                                            r_end <= 1'b0;
                                            r_state <= S_LOW;
                                        end else begin
                                            r_done_val <= r_cur;
                                        end
                                    end
                                end else begin
                                    r_syn <= 1'b1;
                                end
                            end
                            iee_pkg::REQ_OP: begin
                                if (r_phase == PH_OP) begin
                                    r_wait <= i_tok.op;
                                    r_phase <= PH_NUM;
                                end else begin
                                    r_syn <= 1'b1;
                                end
                            end
                            iee_pkg::REQ_END: begin
                                r_a <= r_done_val;
                                r_b <= r_cur;
                                r_alu_op <= r_pend;
                                r_end <= 1'b1;
                                if (r_phase == PH_NUM) r_syn <= 1'b1;
                                if (r_phase == PH_OP && r_have) begin
                                    r_state <= S_LOW;
                                end else begin
                                    r_value <= (r_phase == PH_OP) ? r_cur : '0;
                                    r_state <= S_OUT;
                                end
                            end
                            default: r_syn <= 1'b1;
                        endcase
                    end
                end
                S_MUL: begin
                    if (r_mstep == 2'd0) r_prod <= pp;
                    else r_prod <= r_prod + {pp[31:0], 32'd0};
                    r_mstep <= r_mstep + 1'b1;
                    if (r_mstep == 2'd2) begin
                        r_cur <= r_prod + {pp[31:0], 32'd0};
                        r_state <= S_IDLE;
                    end
                end
                S_DIVW: begin
                    if (div_done) begin
                        if (r_is_mod) r_cur <= r_na ? (64'd0 - remd) : remd;
                        else r_cur <= (r_na != r_nb) ? (64'd0 - quot) : quot;
                        r_state <= S_IDLE;
                    end
                end
                S_LOW: begin
                    if (low_bad) r_bad <= 1'b1;
                    if (r_end) begin
                        r_value <= low_res;
                        r_state <= S_OUT;
                    end else begin
                        r_done_val <= low_res;
                        r_state <= S_IDLE;
                    end
                end
                S_OUT: begin
                    if (!r_valid || !i_stall) begin
                        r_valid <= 1'b1;
                        r_value <= r_syn ? '0 : r_value;
                        r_status <= r_syn;
                        r_odz <= r_dz;
                        r_obad <= r_bad;
                        r_phase <= PH_FIRST;
                        r_done_val <= '0; r_cur <= '0; r_pend <= '0; r_wait <= '0;
                        r_have <= 1'b0; r_syn <= 1'b0; r_dz <= 1'b0; r_bad <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid = r_valid;
    assign o_value = r_syn && (r_state == S_OUT) ? r_value : r_value;
    assign o_status = r_status;
    assign o_div_by_zero = r_odz;
    assign o_bad_operator = r_obad;

    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_tok_pop |-> (r_state == S_IDLE))
        else $error("token taken while busy");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && i_stall) |=> (r_valid && $stable(r_value)))
        else $error("result lost under stall");
    a_syn_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_status) |-> (r_value == '0))
        else $error("syntax error with nonzero value");
    a_div_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_div_start |=> (r_state == S_DIVW))
        else $error("divider started outside divide");
endmodule

### hw/rtl/infix_expression_evaluator_top.sv
// top level of the infix expression evaluator
// Evaluates a flat infix expression delivered as requests: number, operator,
// number ... then an end request, which yields one result (value and three
// flags) and clears the evaluator. Multiply, divide and modulo fold into the
// current term at once; the other operators apply left to right. A front end
// takes requests into a two-entry queue, so the source is held off only when
// the queue is full; the back end drains it one request at a time and takes
// no new request while it multiplies, divides, folds or ends an expression,
// or while a waiting result is held by an output stall. Divide and modulo
// share the bit-serial divider, which does one quotient bit per cycle. The
// result sits in an output register while the next expression is already
// being taken in.
module infix_expression_evaluator_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_stall,
    input  logic [1:0]   i_req_type,
    input  logic [31:0]  i_number,
    input  logic [7:0]   i_operator_char,
    output logic         o_valid,
    input  logic         i_stall,
    output logic [63:0]  o_value,
    output logic         o_status,
    output logic         o_div_by_zero,
    output logic         o_bad_operator
);
    logic          tok_valid, tok_pop;
    iee_pkg::t_tok tok;

    // request intake and queue
    iee_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_req_type(i_req_type), .i_number(i_number),
        .i_operator_char(i_operator_char),
        .o_tok_valid(tok_valid), .o_tok(tok), .i_tok_pop(tok_pop)
    );

    // evaluation and result register
    iee_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_tok_valid(tok_valid), .i_tok(tok), .o_tok_pop(tok_pop),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_value(o_value), .o_status(o_status),
        .o_div_by_zero(o_div_by_zero), .o_bad_operator(o_bad_operator)
    );
endmodule
